// ===== hdl/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared constants, codes and control/status types of the bin packing placer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

    localparam int MAX_BINS = 64;
    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int CNT_W    = $clog2(MAX_BINS + 1);
    localparam int SIZE_W   = 10;
    localparam int IDX_W    = 6;
    localparam int STAT_W   = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(100);

    // register indexes
    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_BIN_CAP  = 1'b1;

    localparam logic MODE_FIRST_FIT = 1'b0;
    localparam logic MODE_BEST_FIT  = 1'b1;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [STAT_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 2'd2;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic issue_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/bpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpp_ctrl
// Request sequencer: accept, scan of the open bins, commit of the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpp_ctrl import bpp_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.issue_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_COMMIT: begin
                // wait for the output register to be free
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_stat.out_free)
        else $error("commit while output register busy");

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE))
        else $error("no return to idle after commit");

    a_load_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN) && !o_cmd.load)
        else $error("load not followed by scan");
`endif

endmodule

`default_nettype wire

// ===== hdl/bpp_dp.sv =====
// ----------------------------------------------------------------------------
// bpp_dp
// Fill level memory, scan pipeline, bin choice and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpp_dp import bpp_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire t_cmd         i_cmd,
    output t_stat             o_stat,
    input  wire               i_fit_mode,
    input  wire  [SIZE_W-1:0] i_bin_capacity,
    input  wire               i_kind,
    input  wire  [SIZE_W-1:0] i_item_size,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [IDX_W-1:0]  o_bin_index,
    output logic              o_opened_new,
    output logic [SIZE_W-1:0] o_room_left,
    output logic [STAT_W-1:0] o_status
);

    logic [SIZE_W-1:0] r_mem [MAX_BINS];
    logic [SIZE_W-1:0] r_rd_data;
    logic [BIN_W-1:0]  r_rd_tag;
    logic              r_rd_vld;

    logic              r_kind;
    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_open;
    logic [CNT_W-1:0]  r_idx;
    logic              r_found;
    logic [BIN_W-1:0]  r_best_idx;
    logic [SIZE_W-1:0] r_best_room;

    logic              r_o_valid;
    logic [IDX_W-1:0]  r_o_idx;
    logic              r_o_new;
    logic [SIZE_W-1:0] r_o_room;
    logic [STAT_W-1:0] r_o_stat;

    logic              in_range;
    logic              do_read;
    logic [SIZE_W:0]   sum;
    logic              fits;
    logic [SIZE_W-1:0] room;
    logic              take;
    logic              out_free;
    logic              full;
    logic [SIZE_W-1:0] new_room;
    logic              mem_we;
    logic [BIN_W-1:0]  mem_wa;
    logic [SIZE_W-1:0] mem_wd;

    assign in_range = (r_idx < r_open);
    assign do_read  = i_cmd.issue && in_range;

    // evaluation of the fill level read in the previous cycle
    assign sum  = {1'b0, r_rd_data} + {1'b0, r_size};
    assign fits = (sum <= {1'b0, i_bin_capacity});
    assign room = i_bin_capacity - sum[SIZE_W-1:0];
    assign take = r_rd_vld && fits &&
                  (!r_found || ((i_fit_mode == MODE_BEST_FIT) && (room < r_best_room)));

    assign out_free = !r_o_valid || !i_out_stall;
    assign full     = (r_open >= CNT_W'(MAX_BINS));
    assign new_room = (r_size <= i_bin_capacity) ? (i_bin_capacity - r_size) : '0;

    assign o_stat.out_free   = out_free;
    assign o_stat.issue_done = (r_kind == KIND_CLEAR) || !in_range ||
                               ((i_fit_mode == MODE_FIRST_FIT) && r_found);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_best_idx;
        mem_wd = sum[SIZE_W-1:0];
        if (i_cmd.commit && (r_kind == KIND_PLACE)) begin
            if (r_found) begin
                mem_we = 1'b1;
                mem_wa = r_best_idx;
                mem_wd = r_best_room;
            end else if (!full) begin
                mem_we = 1'b1;
                mem_wa = r_open[BIN_W-1:0];
                mem_wd = r_size;
            end
        end
    end

    // the chosen bin's new fill is capacity minus its remaining room
    logic [SIZE_W-1:0] wr_data;
    assign wr_data = (r_found && (r_kind == KIND_PLACE)) ?
                     (i_bin_capacity - r_best_room) : mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx[BIN_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_open    <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= do_read;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_kind == KIND_CLEAR) begin
                    r_open <= '0;
                end else if (!r_found && !full) begin
                    r_open <= r_open + CNT_W'(1);
                end
            end
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_size <= i_item_size;
            r_idx  <= '0;
        end else if (do_read) begin
            r_idx  <= r_idx + CNT_W'(1);
        end
        r_rd_tag <= r_idx[BIN_W-1:0];
        if (take) begin
            r_best_idx  <= r_rd_tag;
            r_best_room <= room;
        end
        if (i_cmd.commit) begin
            if (r_kind == KIND_CLEAR) begin
                r_o_idx  <= '0;
                r_o_new  <= 1'b0;
                r_o_room <= '0;
                r_o_stat <= ST_CLEARED;
            end else if (r_found) begin
                r_o_idx  <= IDX_W'(r_best_idx);
                r_o_new  <= 1'b0;
                r_o_room <= r_best_room;
                r_o_stat <= ST_PLACED;
            end else if (full) begin
                r_o_idx  <= '0;
                r_o_new  <= 1'b0;
                r_o_room <= '0;
                r_o_stat <= ST_REJECTED;
            end else begin
                r_o_idx  <= IDX_W'(r_open[BIN_W-1:0]);
                r_o_new  <= 1'b1;
                r_o_room <= new_room;
                r_o_stat <= ST_PLACED;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_bin_index  = r_o_idx;
    assign o_opened_new = r_o_new;
    assign o_room_left  = r_o_room;
    assign o_status     = r_o_stat;

`ifndef SYNTHESIS
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= CNT_W'(MAX_BINS))
        else $error("open bin count beyond bin count");

    a_read_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (CNT_W'(r_rd_tag) < r_open))
        else $error("evaluated a bin that is not open");

    a_chosen_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_found && (r_kind == KIND_PLACE)) |->
        (CNT_W'(r_best_idx) < r_open))
        else $error("chosen bin is not open");
`endif

endmodule

`default_nettype wire

// ===== hdl/bin_packing_placer.sv =====
// ----------------------------------------------------------------------------
// bin_packing_placer
// Online first-fit / best-fit bin packer with an APB register port.
//
// Requests enter on i_in_valid / o_in_stall with i_kind and i_item_size; a
// transfer happens when valid is high and stall is low. Each request gives one
// result on o_out_valid / i_out_stall (bin index, new-bin flag, room left,
// status). The fill levels sit in a single-port-read memory that is scanned
// one bin per cycle; a place request scans the open bins in order, and a
// first-fit hit ends the scan early, while best fit scans them all. A clear
// skips the scan and goes straight to its result. One request is
// worked on at a time; the next is taken as soon as the result is in the
// output register, even while that result waits. A stalled result holds the
// sequencer in its commit step only for the following request.
// Registers: fit_mode at 0x0, bin_capacity at 0x4; write them while idle.
// Reset (synchronous, active low) sets first-fit, capacity 100, no open bins
// and an empty output; fill levels need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bin_packing_placer import bpp_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [APB_AW-1:0] paddr,
    input  wire  [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire               i_kind,
    input  wire  [SIZE_W-1:0] i_item_size,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [IDX_W-1:0]  o_bin_index,
    output logic              o_opened_new,
    output logic [SIZE_W-1:0] o_room_left,
    output logic [STAT_W-1:0] o_status
);

    logic              r_fit_mode;
    logic [SIZE_W-1:0] r_bin_capacity;
    logic              cfg_wr;
    logic              reg_sel;
    t_cmd              cmd;
    t_stat             stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode     <= MODE_FIRST_FIT;
            r_bin_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == REG_FIT_MODE) begin
                r_fit_mode <= pwdata[0];
            end else begin
                r_bin_capacity <= pwdata[SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            REG_FIT_MODE: prdata = APB_DW'(r_fit_mode);
            REG_BIN_CAP:  prdata = APB_DW'(r_bin_capacity);
            default:      prdata = '0;
        endcase
    end

    bpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_fit_mode     (r_fit_mode),
        .i_bin_capacity (r_bin_capacity),
        .i_kind         (i_kind),
        .i_item_size    (i_item_size),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bin_index    (o_bin_index),
        .o_opened_new   (o_opened_new),
        .o_room_left    (o_room_left),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ===== tb/tb_bin_packing_placer.sv =====
// ----------------------------------------------------------------------------
// tb_bin_packing_placer
// Self-checking bench for the online first-fit / best-fit bin packer. A short
// table of hand-picked requests comes first. Some rows carry their expected
// result, and the rest are checked against a built-in packing model. It then
// runs randomized phases over both fit modes and a range of capacities.
// These cover oversize and zero-size items, full bin sets and clears, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bin_packing_placer;
    import bpp_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int MAX_IDLE       = 17;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_REQUESTS = 150;
    localparam int DIRECTED_ROWS  = 22;

    typedef struct packed {
        logic [IDX_W-1:0]  bin_index;
        logic              opened_new;
        logic [SIZE_W-1:0] room_left;
        logic [STAT_W-1:0] status;
    } t_placement;

    typedef struct {
        logic       mode;
        logic       kind;
        logic [9:0] size;
        bit         typed;
        t_placement want;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_kind;
    logic [SIZE_W-1:0] i_item_size;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [IDX_W-1:0]  o_bin_index;
    logic              o_opened_new;
    logic [SIZE_W-1:0] o_room_left;
    logic [STAT_W-1:0] o_status;

    bin_packing_placer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_item_size  (i_item_size),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_bin_index  (o_bin_index),
        .o_opened_new (o_opened_new),
        .o_room_left  (o_room_left),
        .o_status     (o_status)
    );

    // packing model state
    logic              packer_mode;
    logic [SIZE_W-1:0] packer_cap;
    logic [SIZE_W-1:0] fill_level [MAX_BINS];
    int unsigned       bins_open;

    t_placement pending_placements [$];
    int         mismatch_count;
    int         cycle_count;
    int         in_gap_max;
    int         out_stall_max;
    int         stall_left;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd30,   1'b1, '{6'd0, 1'b1, 10'd70,  ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd70,   1'b1, '{6'd0, 1'b0, 10'd0,   ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd0,    1'b1, '{6'd0, 1'b0, 10'd0,   ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd100,  1'b1, '{6'd1, 1'b1, 10'd0,   ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd101,  1'b1, '{6'd2, 1'b1, 10'd0,   ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd1023, 1'b1, '{6'd3, 1'b1, 10'd0,   ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd1,    1'b1, '{6'd4, 1'b1, 10'd99,  ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_CLEAR, 10'd0,    1'b1, '{6'd0, 1'b0, 10'd0,   ST_CLEARED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd0,    1'b1, '{6'd0, 1'b1, 10'd100, ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd512,  1'b1, '{6'd1, 1'b1, 10'd0,   ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd50,   1'b1, '{6'd0, 1'b0, 10'd50,  ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd25,   1'b1, '{6'd0, 1'b0, 10'd25,  ST_PLACED}},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd40,   1'b0, '0},
        '{MODE_FIRST_FIT, KIND_PLACE, 10'd20,   1'b0, '0},
        '{MODE_FIRST_FIT, KIND_CLEAR, 10'd1023, 1'b1, '{6'd0, 1'b0, 10'd0,   ST_CLEARED}},
        '{MODE_BEST_FIT,  KIND_PLACE, 10'd60,   1'b0, '0},
        '{MODE_BEST_FIT,  KIND_PLACE, 10'd70,   1'b0, '0},
        '{MODE_BEST_FIT,  KIND_PLACE, 10'd60,   1'b0, '0},
        '{MODE_BEST_FIT,  KIND_PLACE, 10'd30,   1'b0, '0},
        '{MODE_BEST_FIT,  KIND_PLACE, 10'd10,   1'b0, '0},
        '{MODE_BEST_FIT,  KIND_PLACE, 10'd1023, 1'b0, '0},
        '{MODE_BEST_FIT,  KIND_CLEAR, 10'd0,    1'b1, '{6'd0, 1'b0, 10'd0,   ST_CLEARED}}
    };

    always #5 i_clk = ~i_clk;

    // one request through the packing model
    function automatic t_placement pack_item(input logic kind, input logic [SIZE_W-1:0] size);
        t_placement  r;
        int unsigned i;
        int unsigned sum;
        int unsigned room;
        int unsigned best_room;
        int unsigned chosen;
        bit          found;
        r         = '0;
        found     = 1'b0;
        chosen    = 0;
        best_room = 0;
        if (kind == KIND_CLEAR) begin
            bins_open = 0;
            r.status  = ST_CLEARED;
            return r;
        end
        for (i = 0; i < bins_open; i++) begin
            sum = fill_level[i] + size;
            if (sum <= packer_cap) begin
                room = packer_cap - sum;
                if (packer_mode == MODE_FIRST_FIT) begin
                    chosen = i;
                    found  = 1'b1;
                    break;
                end
                if (!found || room < best_room) begin
                    best_room = room;
                    chosen    = i;
                    found     = 1'b1;
                end
            end
        end
        if (found) begin
            fill_level[chosen] = fill_level[chosen] + size;
            r.bin_index = IDX_W'(chosen);
            r.room_left = packer_cap - fill_level[chosen];
            r.status    = ST_PLACED;
        end else if (bins_open >= MAX_BINS) begin
            r.status = ST_REJECTED;
        end else begin
            fill_level[bins_open] = size;
            r.bin_index  = IDX_W'(bins_open);
            r.opened_new = 1'b1;
            r.room_left  = (size <= packer_cap) ? packer_cap - size : '0;
            r.status     = ST_PLACED;
            bins_open++;
        end
        return r;
    endfunction

    // mostly sizes that fit, with zero, exact, oversize and full-range draws
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned third;
        third = (packer_cap / 3 > 0) ? packer_cap / 3 : 1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return packer_cap;
            2:       return (packer_cap < 1023) ?
                            SIZE_W'($urandom_range(packer_cap + 1, 1023)) : SIZE_W'(1023);
            3:       return SIZE_W'($urandom_range(0, 1023));
            4:       return SIZE_W'($urandom_range(packer_cap / 2 + 1, packer_cap));
            default: return SIZE_W'($urandom_range(1, third));
        endcase
    endfunction

    task automatic write_register(input logic reg_idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_FIT_MODE)
            packer_mode = value[0];
        else
            packer_cap = value[SIZE_W-1:0];
    endtask

    task automatic send_request(input logic kind, input logic [SIZE_W-1:0] size,
                                input bit typed, input t_placement typed_want);
        int         gap;
        t_placement predicted;
        gap = $urandom_range(0, in_gap_max);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_item_size <= size;
        do @(posedge i_clk); while (o_in_stall);
        predicted = pack_item(kind, size);
        pending_placements.insert(pending_placements.size(), typed ? typed_want : predicted);
    endtask

    // hold off until every result is back and the sequencer has gone quiet
    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input t_placement want, input t_placement got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch: bin %0d/%0d new %0d/%0d room %0d/%0d status %0d/%0d",
                     want.bin_index, got.bin_index, want.opened_new, got.opened_new,
                     want.room_left, got.room_left, want.status, got.status,
                     " (expected/actual)");
    endtask

    // result side: random stall per transfer, checks at the rising edge
    always @(negedge i_clk) begin
        i_out_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge i_clk) begin : check_results
        t_placement got;
        t_placement want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_bin_index, o_opened_new, o_room_left, o_status};
            if (pending_placements.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: bin %0d new %0d room %0d status %0d",
                             got.bin_index, got.opened_new, got.room_left, got.status);
            end else begin
                want = pending_placements.pop_front();
                if (got.bin_index !== want.bin_index || got.opened_new !== want.opened_new ||
                    got.room_left !== want.room_left || got.status !== want.status)
                    note_mismatch(want, got);
            end
            stall_left = $urandom_range(0, out_stall_max);
        end
    end

    initial begin : stimulus
        int   phase;
        int   n;
        int   clear_odds;
        logic phase_mode;
        int   phase_cap;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_PLACE;
        i_item_size    = '0;
        i_out_stall    = 1'b0;
        stall_left     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        in_gap_max     = MAX_IDLE;
        out_stall_max  = MAX_IDLE;
        packer_mode    = MODE_FIRST_FIT;
        packer_cap     = CAP_RESET;
        bins_open      = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].mode != packer_mode) begin
                wait_all_results();
                write_register(REG_FIT_MODE, APB_DW'(directed_rows[r].mode));
            end
            send_request(directed_rows[r].kind, directed_rows[r].size,
                         directed_rows[r].typed, directed_rows[r].want);
        end

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin phase_mode = MODE_BEST_FIT;  phase_cap = 1023; end
                1: begin phase_mode = MODE_FIRST_FIT; phase_cap = 1;    end
                2: begin phase_mode = MODE_BEST_FIT;  phase_cap = 1;    end
                3: begin phase_mode = MODE_FIRST_FIT; phase_cap = 1023; end
                default: begin
                    phase_mode = 1'($urandom_range(0, 1));
                    phase_cap  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40)
                                                              : $urandom_range(1, 1023);
                end
            endcase
            wait_all_results();
            write_register(REG_FIT_MODE, APB_DW'(phase_mode));
            write_register(REG_BIN_CAP, APB_DW'(phase_cap));
            in_gap_max    = (phase % 3 == 2) ? 0 : MAX_IDLE;
            out_stall_max = (phase % 4 == 3) ? 0 : MAX_IDLE;
            // odd phases never clear so the bin set runs full
            clear_odds    = (phase % 2 == 1) ? 0 : 25;
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1)
                    send_request(KIND_CLEAR, SIZE_W'($urandom_range(0, 1023)), 1'b0, '0);
                else
                    send_request(KIND_PLACE, pick_size(), 1'b0, '0);
            end
        end

        wait_all_results();
        if (pending_placements.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
